/* rtl/rsi_pkg.sv */
package rsi_pkg;

	localparam int unsigned FRAC_BITS_DEF   = 16;
	localparam int unsigned COORD_WIDTH_DEF = 32;

	typedef enum logic [1:0] {
		ST_HIT      = 2'd0,
		ST_NO_ROOT  = 2'd1,
		ST_BEHIND   = 2'd2,
		ST_ZERO_DIR = 2'd3
	} status_t;

endpackage

/* rtl/rsi_mul.sv */
module rsi_mul #(
	parameter int unsigned AW = 32,
	parameter int unsigned BW = 32,
	parameter int unsigned CW = 32
) (
	input  logic           clk,
	input  logic           en1,
	input  logic           en2,
	input  logic [AW-1:0]  a,
	input  logic [BW-1:0]  b,
	output logic [AW+BW-1:0] p
);

	localparam int unsigned NA = (AW + CW - 1) / CW;
	localparam int unsigned NB = (BW + CW - 1) / CW;
	localparam int unsigned PW = AW + BW;
	localparam int unsigned XW = (NA + NB) * CW;

	logic [NA*CW-1:0] a_x;
	logic [NB*CW-1:0] b_x;
	logic [2*CW-1:0]  pp_s1 [NA][NB];
	logic [XW-1:0]    acc;
	logic [PW-1:0]    p_s2;

	assign a_x = (NA*CW)'(a);
	assign b_x = (NB*CW)'(b);

	always_ff @(posedge clk) begin
		if (en1) begin
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s1[i][j] <= a_x[i*CW +: CW] * b_x[j*CW +: CW];
				end
			end
		end
	end

	always_comb begin
		acc = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				acc = acc + (XW'(pp_s1[i][j]) << (CW * (i + j)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			p_s2 <= acc[PW-1:0];
		end
	end

	assign p = p_s2;

endmodule

/* rtl/rsi_front.sv */
module rsi_front #(
	parameter int unsigned W = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0][W-1:0]     origin,
	input  logic [2:0][W-1:0]     dir,
	input  logic [2:0][W-1:0]     center,
	input  logic [W-2:0]          radius,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2*W-1:0]        a,
	output logic signed [2*W+1:0] h,
	output logic signed [2*W+2:0] c
);

	localparam int unsigned AW  = 2 * W;
	localparam int unsigned HW  = 2 * W + 2;
	localparam int unsigned CDW = 2 * W + 3;

	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	logic signed [W:0]     oc_s1 [3];
	logic signed [W-1:0]   d_s1  [3];
	logic [W-2:0]          r_s1;
	logic signed [2*W-1:0] dd_s2 [3];
	logic signed [2*W+1:0] oo_s2 [3];
	logic signed [2*W:0]   od_s2 [3];
	logic [2*W-3:0]        rr_s2;
	logic [AW-1:0]         a_s3;
	logic signed [HW-1:0]  h_s3;
	logic signed [CDW-1:0] c_s3;

	assign en3      = !v_s3 || out_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			for (int i = 0; i < 3; i++) begin
				oc_s1[i] <= (W+1)'($signed(origin[i])) - (W+1)'($signed(center[i]));
				d_s1[i]  <= $signed(dir[i]);
			end
			r_s1 <= radius;
		end
		if (en2) begin
			for (int i = 0; i < 3; i++) begin
				dd_s2[i] <= d_s1[i] * d_s1[i];
				oo_s2[i] <= oc_s1[i] * oc_s1[i];
				od_s2[i] <= oc_s1[i] * d_s1[i];
			end
			rr_s2 <= r_s1 * r_s1;
		end
		if (en3) begin
			a_s3 <= $unsigned(dd_s2[0]) + $unsigned(dd_s2[1]) + $unsigned(dd_s2[2]);
			h_s3 <= HW'(od_s2[0]) + HW'(od_s2[1]) + HW'(od_s2[2]);
			c_s3 <= CDW'(oo_s2[0]) + CDW'(oo_s2[1]) + CDW'(oo_s2[2])
				- CDW'($signed({1'b0, rr_s2}));
		end
	end

	assign out_valid = v_s3;
	assign a         = a_s3;
	assign h         = h_s3;
	assign c         = c_s3;

endmodule

/* rtl/rsi_disc.sv */
module rsi_disc
	import rsi_pkg::*;
#(
	parameter int unsigned W = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2*W-1:0]        a,
	input  logic signed [2*W+1:0] h,
	input  logic signed [2*W+2:0] c,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [4*W+3:0]        rad,
	output logic [2*W-1:0]        a_out,
	output logic signed [2*W+1:0] h_out,
	output status_t               st
);

	localparam int unsigned AW  = 2 * W;
	localparam int unsigned HW  = 2 * W + 2;
	localparam int unsigned CDW = 2 * W + 3;
	localparam int unsigned DW  = 4 * W + 4;
	localparam int unsigned PW  = 4 * W + 2;
	localparam int unsigned CK  = W + 1;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	logic signed [HW-1:0]  h_neg;
	logic signed [CDW-1:0] c_neg;
	logic [2*W:0]          ha_s1;
	logic [2*W+1:0]        ca_s1;
	logic                  cn_s1, cn_s2, cn_s3;
	logic                  z_s1, z_s2, z_s3;
	logic [AW-1:0]         a_s1, a_s2, a_s3, a_s4;
	logic signed [HW-1:0]  h_s1, h_s2, h_s3, h_s4;
	logic [PW-1:0]         hh, ac;
	logic [DW-1:0]         dsc;
	logic [DW-1:0]         rad_s4;
	status_t               st_s4;

	assign en4      = !v_s4 || out_ready;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	assign h_neg = -h;
	assign c_neg = -c;

	always_ff @(posedge clk) begin
		if (en1) begin
			ha_s1 <= h[HW-1] ? h_neg[2*W:0] : h[2*W:0];
			ca_s1 <= c[CDW-1] ? c_neg[2*W+1:0] : c[2*W+1:0];
			cn_s1 <= c[CDW-1];
			z_s1  <= (a == '0);
			a_s1  <= a;
			h_s1  <= h;
		end
		if (en2) begin
			cn_s2 <= cn_s1;
			z_s2  <= z_s1;
			a_s2  <= a_s1;
			h_s2  <= h_s1;
		end
		if (en3) begin
			cn_s3 <= cn_s2;
			z_s3  <= z_s2;
			a_s3  <= a_s2;
			h_s3  <= h_s2;
		end
	end

	rsi_mul #(.AW(2*W+1), .BW(2*W+1), .CW(CK)) u_mul_hh (
		.clk (clk),
		.en1 (en2),
		.en2 (en3),
		.a   (ha_s1),
		.b   (ha_s1),
		.p   (hh)
	);

	rsi_mul #(.AW(AW), .BW(2*W+2), .CW(CK)) u_mul_ac (
		.clk (clk),
		.en1 (en2),
		.en2 (en3),
		.a   (a_s1),
		.b   (ca_s1),
		.p   (ac)
	);

	assign dsc = cn_s3 ? (DW'(hh) + DW'(ac)) : (DW'(hh) - DW'(ac));

	always_ff @(posedge clk) begin
		if (en4) begin
			rad_s4 <= dsc;
			a_s4   <= a_s3;
			h_s4   <= h_s3;
			if (z_s3) begin
				st_s4 <= ST_ZERO_DIR;
			end else if (dsc[DW-1]) begin
				st_s4 <= ST_NO_ROOT;
			end else begin
				st_s4 <= ST_HIT;
			end
		end
	end

	assign out_valid = v_s4;
	assign rad       = rad_s4;
	assign a_out     = a_s4;
	assign h_out     = h_s4;
	assign st        = st_s4;

endmodule

/* rtl/rsi_sqrt.sv */
module rsi_sqrt
	import rsi_pkg::*;
#(
	parameter int unsigned W = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [4*W+3:0]        rad,
	input  logic [2*W-1:0]        a,
	input  logic signed [2*W+1:0] h,
	input  status_t               st,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2*W+1:0]        root,
	output logic [2*W-1:0]        a_out,
	output logic signed [2*W+1:0] h_out,
	output status_t               st_out
);

	localparam int unsigned SW   = 2 * W + 2;
	localparam int unsigned RW   = 2 * SW;
	localparam int unsigned REMW = SW + 3;
	localparam int unsigned AW   = 2 * W;
	localparam int unsigned HW   = 2 * W + 2;

	logic [SW-1:0]        v_s;
	logic [SW-1:0]        en;
	logic [REMW-1:0]      rem_s  [SW-1];
	logic [RW-1:0]        rad_s  [SW-1];
	logic [SW-1:0]        root_s [SW];
	logic [AW-1:0]        a_s    [SW];
	logic signed [HW-1:0] h_s    [SW];
	status_t              st_s   [SW];
	logic [REMW-1:0]      rem_n  [SW];
	logic [SW-1:0]        root_n [SW];
	logic [RW-1:0]        rad_n  [SW];

	for (genvar k = 0; k < SW; k++) begin : g_en
		if (k == SW - 1) begin : g_last
			assign en[k] = !v_s[k] || out_ready;
		end else begin : g_mid
			assign en[k] = !v_s[k] || en[k+1];
		end
	end

	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (en[0]) v_s[0] <= in_valid;
			for (int k = 1; k < SW; k++) begin
				if (en[k]) v_s[k] <= v_s[k-1];
			end
		end
	end

	always_comb begin
		logic [REMW-1:0] rp, rt, tr;
		logic [SW-1:0]   qp;
		logic [RW-1:0]   dp;
		for (int k = 0; k < SW; k++) begin
			if (k == 0) begin
				rp = '0;
				qp = '0;
				dp = rad;
			end else begin
				rp = rem_s[k-1];
				qp = root_s[k-1];
				dp = rad_s[k-1];
			end
			rt = {rp[REMW-3:0], dp[RW-1 -: 2]};
			tr = REMW'({qp, 2'b01});
			if (rt >= tr) begin
				rem_n[k]  = rt - tr;
				root_n[k] = {qp[SW-2:0], 1'b1};
			end else begin
				rem_n[k]  = rt;
				root_n[k] = {qp[SW-2:0], 1'b0};
			end
			rad_n[k] = dp << 2;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			a_s[0]  <= a;
			h_s[0]  <= h;
			st_s[0] <= st;
		end
		for (int k = 1; k < SW; k++) begin
			if (en[k]) begin
				a_s[k]  <= a_s[k-1];
				h_s[k]  <= h_s[k-1];
				st_s[k] <= st_s[k-1];
			end
		end
		for (int k = 0; k < SW; k++) begin
			if (en[k]) begin
				root_s[k] <= root_n[k];
			end
		end
		for (int k = 0; k < SW - 1; k++) begin
			if (en[k]) begin
				rem_s[k] <= rem_n[k];
				rad_s[k] <= rad_n[k];
			end
		end
	end

	assign out_valid = v_s[SW-1];
	assign root      = root_s[SW-1];
	assign a_out     = a_s[SW-1];
	assign h_out     = h_s[SW-1];
	assign st_out    = st_s[SW-1];

endmodule

/* rtl/rsi_div.sv */
module rsi_div
	import rsi_pkg::*;
#(
	parameter int unsigned W = 32,
	parameter int unsigned F = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2*W+1:0]        root,
	input  logic [2*W-1:0]        a,
	input  logic signed [2*W+1:0] h,
	input  status_t               st,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  hit,
	output logic [W-2:0]          distance,
	output status_t               status
);

	localparam int unsigned AW   = 2 * W;
	localparam int unsigned NW   = 2 * W + 4;
	localparam int unsigned PNW  = 2 * W + 3;
	localparam int unsigned NUMW = PNW + F;
	localparam int unsigned CMPW = NUMW + AW + W;
	localparam int unsigned QN   = W - 1;

	logic v_s1, v_s2, vo_q;
	logic en1, en2, eno;
	logic [QN-1:0] vd_s;
	logic [QN-1:0] end_s;

	logic signed [NW-1:0] hx, sx, n0, n1;
	logic                 pos0, pos1;

	logic [PNW-1:0]  n_s1;
	logic [AW-1:0]   a_s1, a_s2;
	status_t         st_s1, st_s2;
	logic [NUMW-1:0] num;
	logic            sat_s2;
	logic [AW:0]     rem_s2;
	logic [QN-1:0]   low_s2;

	logic [AW:0]     rem_sd [QN-1];
	logic [QN-1:0]   low_sd [QN-1];
	logic [QN-1:0]   q_sd   [QN];
	logic [AW-1:0]   a_sd   [QN-1];
	logic            sat_sd [QN];
	status_t         st_sd  [QN];
	logic [AW:0]     rem_n  [QN];
	logic [QN-1:0]   q_n    [QN];
	logic [QN-1:0]   low_n  [QN];

	logic            hit_q;
	logic [W-2:0]    dist_q;
	status_t         st_q;

	assign eno = !vo_q || out_ready;
	for (genvar k = 0; k < QN; k++) begin : g_en
		if (k == QN - 1) begin : g_last
			assign end_s[k] = !vd_s[k] || eno;
		end else begin : g_mid
			assign end_s[k] = !vd_s[k] || end_s[k+1];
		end
	end
	assign en2      = !v_s2 || end_s[0];
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			vd_s <= '0;
			vo_q <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (end_s[0]) vd_s[0] <= v_s2;
			for (int k = 1; k < QN; k++) begin
				if (end_s[k]) vd_s[k] <= vd_s[k-1];
			end
			if (eno) vo_q <= vd_s[QN-1];
		end
	end

	assign hx   = NW'(h);
	assign sx   = $signed(NW'(root));
	assign n0   = -hx - sx;
	assign n1   = -hx + sx;
	assign pos0 = !n0[NW-1] && (n0 != '0);
	assign pos1 = !n1[NW-1] && (n1 != '0);

	always_ff @(posedge clk) begin
		if (en1) begin
			a_s1 <= a;
			n_s1 <= pos0 ? n0[PNW-1:0] : n1[PNW-1:0];
			if (st == ST_HIT && !pos0 && !pos1) begin
				st_s1 <= ST_BEHIND;
			end else begin
				st_s1 <= st;
			end
		end
	end

	assign num = {n_s1, {F{1'b0}}};

	always_ff @(posedge clk) begin
		if (en2) begin
			a_s2   <= a_s1;
			st_s2  <= st_s1;
			sat_s2 <= CMPW'(num) >= (CMPW'(a_s1) << (W - 1));
			rem_s2 <= (AW+1)'(num >> (W - 1));
			low_s2 <= num[QN-1:0];
		end
	end

	always_comb begin
		logic [AW:0]   rp, rt;
		logic [QN-1:0] qp, lp;
		for (int k = 0; k < QN; k++) begin
			if (k == 0) begin
				rp = rem_s2;
				qp = '0;
				lp = low_s2;
			end else begin
				rp = rem_sd[k-1];
				qp = q_sd[k-1];
				lp = low_sd[k-1];
			end
			rt = {rp[AW-1:0], lp[QN-1]};
			if (rt >= (AW+1)'(k == 0 ? a_s2 : a_sd[k-1])) begin
				rem_n[k] = rt - (AW+1)'(k == 0 ? a_s2 : a_sd[k-1]);
				q_n[k]   = {qp[QN-2:0], 1'b1};
			end else begin
				rem_n[k] = rt;
				q_n[k]   = {qp[QN-2:0], 1'b0};
			end
			low_n[k] = lp << 1;
		end
	end

	always_ff @(posedge clk) begin
		if (end_s[0]) begin
			a_sd[0]   <= a_s2;
			sat_sd[0] <= sat_s2;
			st_sd[0]  <= st_s2;
		end
		for (int k = 1; k < QN; k++) begin
			if (end_s[k]) begin
				sat_sd[k] <= sat_sd[k-1];
				st_sd[k]  <= st_sd[k-1];
			end
		end
		for (int k = 1; k < QN - 1; k++) begin
			if (end_s[k]) begin
				a_sd[k] <= a_sd[k-1];
			end
		end
		for (int k = 0; k < QN; k++) begin
			if (end_s[k]) begin
				q_sd[k] <= q_n[k];
			end
		end
		for (int k = 0; k < QN - 1; k++) begin
			if (end_s[k]) begin
				rem_sd[k] <= rem_n[k];
				low_sd[k] <= low_n[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (eno) begin
			st_q  <= st_sd[QN-1];
			hit_q <= (st_sd[QN-1] == ST_HIT);
			if (st_sd[QN-1] != ST_HIT) begin
				dist_q <= '0;
			end else if (sat_sd[QN-1]) begin
				dist_q <= '1;
			end else begin
				dist_q <= q_sd[QN-1];
			end
		end
	end

	assign out_valid = vo_q;
	assign hit       = hit_q;
	assign distance  = dist_q;
	assign status    = st_q;

endmodule

/* rtl/ray_sphere_intersection.sv */
// Ray-sphere intersection in signed fixed point (FRAC_BITS fraction bits). Each word carries
// one ray and one sphere and returns whether the ray hits, the nearest positive distance
// (saturated to the largest positive value) and a status code. The design is a fully
// pipelined datapath that takes a new word every cycle while in_ready is high; in_ready drops
// only when every stage holds a word behind a stalled output. Its square root is bit-per-stage
// (2*COORD_WIDTH+2 stages), as is its divider (COORD_WIDTH-1 stages); empty stages close up
// under a stall, so input words are still taken while a finished result waits at the output.
module ray_sphere_intersection
	import rsi_pkg::*;
#(
	parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF,
	parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [COORD_WIDTH-1:0] origin_x,
	input  logic [COORD_WIDTH-1:0] origin_y,
	input  logic [COORD_WIDTH-1:0] origin_z,
	input  logic [COORD_WIDTH-1:0] dir_x,
	input  logic [COORD_WIDTH-1:0] dir_y,
	input  logic [COORD_WIDTH-1:0] dir_z,
	input  logic [COORD_WIDTH-1:0] center_x,
	input  logic [COORD_WIDTH-1:0] center_y,
	input  logic [COORD_WIDTH-1:0] center_z,
	input  logic [COORD_WIDTH-2:0] sphere_radius,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   hit,
	output logic [COORD_WIDTH-2:0] distance,
	output logic [1:0]             status
);

	localparam int unsigned W = COORD_WIDTH;

	logic [2:0][W-1:0] origin, dir, center;

	logic                  f_valid, f_ready;
	logic [2*W-1:0]        f_a;
	logic signed [2*W+1:0] f_h;
	logic signed [2*W+2:0] f_c;

	logic                  d_valid, d_ready;
	logic [4*W+3:0]        d_rad;
	logic [2*W-1:0]        d_a;
	logic signed [2*W+1:0] d_h;
	status_t               d_st;

	logic                  s_valid, s_ready;
	logic [2*W+1:0]        s_root;
	logic [2*W-1:0]        s_a;
	logic signed [2*W+1:0] s_h;
	status_t               s_st;

	status_t               o_st;

	assign origin = {origin_z, origin_y, origin_x};
	assign dir    = {dir_z, dir_y, dir_x};
	assign center = {center_z, center_y, center_x};

	rsi_front #(.W(W)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.origin    (origin),
		.dir       (dir),
		.center    (center),
		.radius    (sphere_radius),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.a         (f_a),
		.h         (f_h),
		.c         (f_c)
	);

	rsi_disc #(.W(W)) u_disc (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.a         (f_a),
		.h         (f_h),
		.c         (f_c),
		.out_valid (d_valid),
		.out_ready (d_ready),
		.rad       (d_rad),
		.a_out     (d_a),
		.h_out     (d_h),
		.st        (d_st)
	);

	rsi_sqrt #(.W(W)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (d_valid),
		.in_ready  (d_ready),
		.rad       (d_rad),
		.a         (d_a),
		.h         (d_h),
		.st        (d_st),
		.out_valid (s_valid),
		.out_ready (s_ready),
		.root      (s_root),
		.a_out     (s_a),
		.h_out     (s_h),
		.st_out    (s_st)
	);

	rsi_div #(.W(W), .F(FRAC_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_valid),
		.in_ready  (s_ready),
		.root      (s_root),
		.a         (s_a),
		.h         (s_h),
		.st        (s_st),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.hit       (hit),
		.distance  (distance),
		.status    (o_st)
	);

	assign status = o_st;

`ifndef SYNTHESIS
	a_miss_zero_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> distance == '0)
		else $error("Missed ray reports a nonzero distance.");

	a_hit_matches_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hit == (o_st == ST_HIT)))
		else $error("Hit flag disagrees with status.");

	a_ready_flows: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("Pipeline refuses input while the output is drained.");
`endif

endmodule
